/* sv/roc_pkg.sv */
// Package for the ROC AUC scorer: sizes, item/result/token types, tail states.
// No dependencies; used by every other file of the block.
package roc_pkg;
    localparam int MAX_ITEMS  = 1024;
    localparam int SCORE_BITS = 32;
    localparam int IDX_W      = $clog2(MAX_ITEMS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int CREDIT_W   = 20;
    localparam int AUC_W      = 17;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = 2 * CNT_W;
    localparam int DIVR_W     = PROD_W + 1;
    localparam int REM_W      = DIVR_W + 1;
    localparam int DVD_W      = CREDIT_W + FRAC_BITS;
    localparam int STEP_W     = $clog2(DVD_W + 1);

    typedef struct packed {
        logic signed [31:0] score;
        logic               label;
        logic               final_item;
    } t_item;

    typedef struct packed {
        logic [AUC_W-1:0]    auc_fraction;
        logic [CREDIT_W-1:0] pair_credit;
        logic [CNT_W-1:0]    positives_seen;
        logic [CNT_W-1:0]    negatives_seen;
        logic                degenerate;
        logic                overflowed;
    } t_result;

    // Item travelling down the cell row.
    typedef struct packed {
        logic                  valid;
        logic                  drop;
        logic                  last;
        logic                  label;
        logic [SCORE_BITS-1:0] key;
        logic [IDX_W-1:0]      idx;
        logic [CREDIT_W-1:0]   credit;
    } t_token;

    typedef enum logic [1:0] {
        T_IDLE,
        T_MUL,
        T_DIV,
        T_OUT
    } t_tail_state;
endpackage

/* sv/roc_if.sv */
// Valid/ready channel interfaces for the scorer's input items and results.
// Depends on roc_pkg for the payload types.
interface roc_in_if;
    logic            valid;
    logic            ready;
    roc_pkg::t_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface roc_out_if;
    logic             valid;
    logic             ready;
    roc_pkg::t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/roc_cell.sv */
// One cell of the scoring row: stores one item and scores every later item
// that passes it. Depends on roc_pkg.
module roc_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [roc_pkg::IDX_W-1:0]   i_index,
    input  roc_pkg::t_token             i_tok,
    output roc_pkg::t_token             o_tok
);
    logic [roc_pkg::SCORE_BITS-1:0] r_key;
    logic                           r_label;
    roc_pkg::t_token                r_tok;
    roc_pkg::t_token                n_tok;
    logic                           w_live;

    // Only cells below the item's own slot hold items of the current set.
    assign w_live = i_tok.valid && !i_tok.drop && (i_tok.idx > i_index);

    always_comb begin
        n_tok = i_tok;
        if (w_live && (r_label != i_tok.label)) begin
            if (i_tok.key == r_key) begin
                n_tok.credit = i_tok.credit + roc_pkg::CREDIT_W'(1);
            end else if (i_tok.label ? (i_tok.key > r_key) : (r_key > i_tok.key)) begin
                n_tok.credit = i_tok.credit + roc_pkg::CREDIT_W'(2);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (i_en) begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_tok.valid && !i_tok.drop && (i_tok.idx == i_index)) begin
            r_key   <= i_tok.key;
            r_label <= i_tok.label;
        end
    end

    assign o_tok = r_tok;
endmodule

/* sv/roc_tail.sv */
// End of the cell row: sums credit and class counts, then divides for the
// AUC with a bit-serial restoring divider. Depends on roc_pkg.
module roc_tail (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  roc_pkg::t_token   i_tok,
    output logic              o_en,
    output logic              o_valid,
    input  logic              i_ready,
    output roc_pkg::t_result  o_data
);
    roc_pkg::t_tail_state r_state, n_state;
    logic [roc_pkg::CREDIT_W-1:0] r_credit, n_credit;
    logic [roc_pkg::CNT_W-1:0]    r_pos, n_pos, r_neg, n_neg;
    logic                         r_ovf, n_ovf;
    roc_pkg::t_result             r_res;
    logic [roc_pkg::DIVR_W-1:0]   r_divisor;
    logic [roc_pkg::REM_W-1:0]    r_rem;
    logic [roc_pkg::REM_W-1:0]    w_rem_sh;
    logic [roc_pkg::DVD_W-1:0]    r_dvd;
    logic [roc_pkg::AUC_W-1:0]    r_quo;
    logic [roc_pkg::STEP_W-1:0]   r_step;
    logic                         w_take, w_fin, w_busy, w_qbit;

    assign w_take = o_en && i_tok.valid;
    assign w_fin  = w_take && i_tok.last;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            roc_pkg::T_IDLE: if (w_fin) n_state = roc_pkg::T_MUL;
            roc_pkg::T_MUL:  n_state = r_res.degenerate ? roc_pkg::T_OUT : roc_pkg::T_DIV;
            roc_pkg::T_DIV:  if (r_step == roc_pkg::STEP_W'(roc_pkg::DVD_W - 1))
                                 n_state = roc_pkg::T_OUT;
            roc_pkg::T_OUT:  if (i_ready) n_state = roc_pkg::T_IDLE;
            default:         n_state = roc_pkg::T_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        w_busy  = (r_state != roc_pkg::T_IDLE);
        o_valid = (r_state == roc_pkg::T_OUT);
    end

    // Row halts only while a final item waits for the tail to finish the previous result.
    assign o_en = !(i_tok.valid && i_tok.last && w_busy);

    always_comb begin
        n_credit = r_credit;
        n_pos    = r_pos;
        n_neg    = r_neg;
        n_ovf    = r_ovf;
        if (w_take) begin
            if (i_tok.drop) begin
                n_ovf = 1'b1;
            end else begin
                n_credit = r_credit + i_tok.credit;
                if (i_tok.label) n_pos = r_pos + roc_pkg::CNT_W'(1);
                else             n_neg = r_neg + roc_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= roc_pkg::T_IDLE;
            r_credit <= '0;
            r_pos    <= '0;
            r_neg    <= '0;
            r_ovf    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fin) begin
                r_credit <= '0;
                r_pos    <= '0;
                r_neg    <= '0;
                r_ovf    <= 1'b0;
            end else begin
                r_credit <= n_credit;
                r_pos    <= n_pos;
                r_neg    <= n_neg;
                r_ovf    <= n_ovf;
            end
        end
    end

    assign w_rem_sh = {r_rem[roc_pkg::REM_W-2:0], r_dvd[roc_pkg::DVD_W-1]};
    assign w_qbit   = (w_rem_sh >= {1'b0, r_divisor});

    always_ff @(posedge i_clk) begin
        if (w_fin) begin
            r_res.pair_credit    <= n_credit;
            r_res.positives_seen <= n_pos;
            r_res.negatives_seen <= n_neg;
            r_res.overflowed     <= n_ovf;
            r_res.degenerate     <= (n_pos == '0) || (n_neg == '0);
            r_res.auc_fraction   <= '0;
        end else if (r_state == roc_pkg::T_MUL) begin
            // Full-width product: 2 * P * N.
            r_divisor <= {roc_pkg::PROD_W'(r_res.positives_seen)
                          * roc_pkg::PROD_W'(r_res.negatives_seen), 1'b0};
            r_dvd     <= {r_res.pair_credit, roc_pkg::FRAC_BITS'(0)};
            r_rem     <= '0;
            r_quo     <= '0;
            r_step    <= '0;
        end else if (r_state == roc_pkg::T_DIV) begin
            r_rem  <= w_qbit ? (w_rem_sh - {1'b0, r_divisor}) : w_rem_sh;
            r_dvd  <= {r_dvd[roc_pkg::DVD_W-2:0], 1'b0};
            r_quo  <= {r_quo[roc_pkg::AUC_W-2:0], w_qbit};
            r_step <= r_step + roc_pkg::STEP_W'(1);
            if (r_step == roc_pkg::STEP_W'(roc_pkg::DVD_W - 1))
                r_res.auc_fraction <= {r_quo[roc_pkg::AUC_W-2:0], w_qbit};
        end
    end

    assign o_data = r_res;
endmodule

/* sv/roc_auc_scorer.sv */
// Top level of the streaming ROC AUC scorer: entry logic, cell row, tail.
// Depends on roc_pkg, roc_if, roc_cell and roc_tail.
//
// Usage: labelled scores enter on i_item (valid/ready), one transaction per
// cycle while ready is high. The item flagged final_item closes the data set;
// for it one result transaction leaves on o_result with the AUC in Q1.16,
// pair credit, class counts, degenerate and overflowed flags. Other items
// give no result.
// Each item walks a row of MAX_ITEMS cells, one cell per cycle while the row
// is not halted; the cell whose slot matches the item's index stores it, and
// every earlier cell adds credit for an opposite-label pair in order or tied.
// Items stream at one per cycle unless the row halts. After a final item has
// crossed the row, the tail forms 2 * P * N and divides, one quotient bit per
// cycle for 36 bits; a degenerate set skips the division.
// A new data set may follow the final item at once. Items beyond MAX_ITEMS
// in a set are dropped and reported in overflowed.
// Reset empties the row and clears all counts. If the receiver stalls, the
// result is held and the row halts only when the next final item reaches
// the tail; ready then drops until the result is taken.
module roc_auc_scorer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    roc_in_if.sink     i_item,
    roc_out_if.source  o_result
);
    logic [roc_pkg::CNT_W-1:0] r_count;
    logic                      w_en, w_acc, w_full;
    roc_pkg::t_token           w_tok [roc_pkg::MAX_ITEMS+1];

    assign i_item.ready = w_en;
    assign w_acc  = i_item.valid && w_en;
    assign w_full = (r_count == roc_pkg::CNT_W'(roc_pkg::MAX_ITEMS));

    always_comb begin
        w_tok[0].valid  = w_acc;
        w_tok[0].drop   = w_full;
        w_tok[0].last   = i_item.data.final_item;
        w_tok[0].label  = i_item.data.label;
        // Flip the sign bit so an unsigned compare keeps signed order.
        w_tok[0].key    = i_item.data.score ^ {1'b1, {(roc_pkg::SCORE_BITS-1){1'b0}}};
        w_tok[0].idx    = r_count[roc_pkg::IDX_W-1:0];
        w_tok[0].credit = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_acc) begin
            if (i_item.data.final_item) r_count <= '0;
            else if (!w_full)           r_count <= r_count + roc_pkg::CNT_W'(1);
        end
    end

    for (genvar k = 0; k < roc_pkg::MAX_ITEMS; k++) begin : g_cell
        roc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_index (roc_pkg::IDX_W'(k)),
            .i_tok   (w_tok[k]),
            .o_tok   (w_tok[k+1])
        );
    end

    roc_tail u_tail (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (w_tok[roc_pkg::MAX_ITEMS]),
        .o_en    (w_en),
        .o_valid (o_result.valid),
        .i_ready (o_result.ready),
        .o_data  (o_result.data)
    );
endmodule

/* sv/roc_chk.sv */
// Port-level checks on the scorer's result channel, bound to the top level.
// Depends on roc_pkg.
module roc_chk (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             i_ready,
    input roc_pkg::t_result i_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_data))
        else $error("result changed while stalled");

    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_data.degenerate ==
            ((i_data.positives_seen == '0) || (i_data.negatives_seen == '0)))
        else $error("degenerate flag disagrees with counts");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_data.degenerate |-> i_data.auc_fraction == '0)
        else $error("degenerate result with nonzero auc");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_data.auc_fraction <= roc_pkg::AUC_W'(65536))
        else $error("auc above one");

    a_rst: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_valid)
        else $error("result valid right after reset");
endmodule

bind roc_auc_scorer roc_chk u_roc_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_result.valid),
    .i_ready (o_result.ready),
    .i_data  (o_result.data)
);

/* test/roc_auc_checker.sv */
`timescale 1ns / 1ps
// Checker for the ROC AUC scorer: watches both channels, predicts each result.
// Depends on roc_pkg and roc_if.
module roc_auc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    roc_in_if.sink      i_item_mon,
    roc_out_if.sink     i_result_mon,
    output int          o_fail_count,
    output int          o_pending
);
    import roc_pkg::*;

    logic [SCORE_BITS-1:0] key_mem [MAX_ITEMS];
    logic                  lab_mem [MAX_ITEMS];
    int unsigned           n_items;
    int unsigned           n_pos;
    longint unsigned       credit_acc;
    logic                  dropped;
    t_result               auc_queue[$];

    assign o_pending = auc_queue.size();

    // Scores one accepted item against the stored set; for a final item, queues the expected result.
    task automatic score_item(input t_item it);
        logic [SCORE_BITS-1:0] k;
        longint unsigned p, n, a;
        t_result r;
        k = it.score ^ (1 << (SCORE_BITS - 1));
        if (n_items < MAX_ITEMS) begin
            for (int i = 0; i < n_items; i++) begin
                if (lab_mem[i] != it.label) begin
                    if (k == key_mem[i]) credit_acc += 1;
                    else if (it.label ? (k > key_mem[i]) : (key_mem[i] > k)) credit_acc += 2;
                end
            end
            key_mem[n_items] = k;
            lab_mem[n_items] = it.label;
            n_items++;
            if (it.label) n_pos++;
        end else begin
            dropped = 1'b1;
        end
        if (it.final_item) begin
            p = n_pos;
            n = n_items - n_pos;
            a = 0;
            r.degenerate = (p == 0 || n == 0);
            if (!r.degenerate) a = (credit_acc << FRAC_BITS) / (2 * p * n);
            r.auc_fraction   = a[AUC_W-1:0];
            r.pair_credit    = credit_acc[CREDIT_W-1:0];
            r.positives_seen = p[CNT_W-1:0];
            r.negatives_seen = n[CNT_W-1:0];
            r.overflowed     = dropped;
            auc_queue.push_back(r);
            n_items = 0; n_pos = 0; credit_acc = 0; dropped = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            n_items <= 0; n_pos <= 0; credit_acc <= 0; dropped <= 1'b0;
            o_fail_count <= 0;
        end else begin
            if (i_item_mon.valid && i_item_mon.ready) score_item(i_item_mon.data);
            if (i_result_mon.valid && i_result_mon.ready) begin
                if (auc_queue.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, i_result_mon.data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    t_result e;
                    t_result g;
                    e = auc_queue.pop_front();
                    g = i_result_mon.data;
                    if (g !== e) begin
                        $display("%0t: expected %p actual %p", $time, e, g);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

/* test/roc_auc_scorer_tb.sv */
`timescale 1ns / 1ps
// Top of the ROC AUC scorer testbench: clock, reset, stimulus, verdict.
// Depends on roc_pkg, roc_if, roc_auc_scorer and roc_auc_checker.
module roc_auc_scorer_tb;
    import roc_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_WAIT = MAX_ITEMS + 100;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    bit   stim_done;
    bit   hold_rx;

    roc_in_if  item_ch();
    roc_out_if result_ch();

    roc_auc_scorer dut (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(item_ch), .o_result(result_ch));
    roc_auc_checker chk (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_item_mon(item_ch),
        .i_result_mon(result_ch), .o_fail_count(fail_count), .o_pending(pending));

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Score drawn from a narrow band near zero or the most negative value so ties occur, or the full range.
    function automatic logic [31:0] pick_score();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 7) - 4;
            1: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'h0} | $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic send(input logic [31:0] s, input logic l, input logic f);
        int g;
        g = gap_len();
        repeat (g) @(posedge i_clk);
        item_ch.valid <= 1'b1;
        item_ch.data  <= '{score: s, label: l, final_item: f};
        do @(posedge i_clk); while (!item_ch.ready);
        item_ch.valid <= 1'b0;
    endtask

    task automatic send_set(input int len);
        for (int i = 0; i < len; i++)
            send(pick_score(), $urandom_range(0, 1), i == len - 1);
    endtask

    // Receiver: random stalls, one long hold-off requested by stimulus.
    initial begin
        result_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_rx) begin
                result_ch.ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            result_ch.ready <= 1'b1;
            @(posedge i_clk);
            if ($urandom_range(0, 2) == 0) begin
                result_ch.ready <= 1'b0;
                repeat (gap_len()) @(posedge i_clk);
            end
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else if (++idle_cycles >= IDLE_LIMIT) begin
                $display("roc_auc_scorer: mismatch");
                $finish;
            end
        end
    end

    initial begin
        int sent;
        item_ch.valid = 1'b0;
        item_ch.data  = '0;
        stim_done = 1'b0;
        hold_rx = 1'b0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed: extremes, ties, degenerate sets, single item.
        send(32'h7FFFFFFF, 1'b1, 1'b0);
        send(32'h80000000, 1'b0, 1'b1);
        send(32'h80000000, 1'b1, 1'b0);
        send(32'h7FFFFFFF, 1'b0, 1'b1);
        send(32'h00000005, 1'b1, 1'b0);
        send(32'h00000005, 1'b0, 1'b1);
        send(32'hFFFFFFFF, 1'b1, 1'b0);
        send(32'h00000000, 1'b1, 1'b1);
        send(32'h12345678, 1'b0, 1'b0);
        send(32'h00000001, 1'b0, 1'b1);
        send(32'hA5A5A5A5, 1'b1, 1'b1);
        send(32'hFFFFFFFE, 1'b0, 1'b0);
        send(32'h00000002, 1'b1, 1'b0);
        send(32'hFFFFFFFE, 1'b1, 1'b1);
        // Overflow: fill the store past capacity; final item is dropped too.
        for (int i = 0; i < MAX_ITEMS + 3; i++)
            send($urandom, i[0], i == MAX_ITEMS + 2);
        // Long receiver hold-off while items keep coming.
        hold_rx = 1'b1;
        for (int k = 0; k < 6; k++) send_set($urandom_range(1, 5));
        sent = 0;
        while (sent < 650) begin
            int len;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
            send_set(len);
            sent += len;
        end
        stim_done = 1'b1;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("roc_auc_scorer: match");
        else
            $display("roc_auc_scorer: mismatch");
        $finish;
    end
endmodule
